/* hdl/bucketed_min_priority_queue_macros.svh */
// Assertion macros used by the queue datapath.
`ifndef BUCKETED_MIN_PRIORITY_QUEUE_MACROS_SVH
`define BUCKETED_MIN_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
`define BMPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BMPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/bmpq_pkg.sv */
`timescale 1ns / 1ps
package bmpq_pkg;

  localparam int unsigned NUM_BUCKETS_DEF  = 256;
  localparam int unsigned BUCKET_DEPTH_DEF = 16;
  localparam int unsigned CNT_W            = 13;

  localparam logic [1:0] CFG_BUCKET_START = 2'd0;
  localparam logic [1:0] CFG_INV_STEP     = 2'd1;
  localparam logic [1:0] CFG_LAST_BUCKET  = 2'd2;

  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_CONSUME = 2'd2;
  localparam logic [1:0] REQ_RSVD    = 2'd3;

  localparam logic [31:0] BUCKET_START_RST = 32'h0000_0000;
  localparam logic [31:0] INV_STEP_RST     = 32'h0001_0000;
  localparam logic [7:0]  LAST_BUCKET_RST  = 8'hFF;

  typedef enum logic [1:0] {ST_OK, ST_EMPTY, ST_NOT_FOUND, ST_FULL} status_e;
  typedef enum logic [1:0] {RD_PREV, RD_CUR, RD_NEXT} rd_sel_e;
  typedef enum logic [2:0] {PTR_HOLD, PTR_FILL, PTR_ZERO, PTR_DEC, PTR_INC,
                            PTR_FILL_M1} ptr_op_e;
  typedef enum logic [1:0] {CM_NONE, CM_INSERT, CM_REMOVE, CM_POP} commit_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] key;
    logic [15:0]        tag_id;
  } req_t;

  typedef struct packed {
    logic [15:0]      out_id;
    logic [1:0]       status;
    logic [CNT_W-1:0] queue_count;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [15:0]        tag_id;
  } entry_t;

  typedef struct packed {
    logic    capture;
    logic    diff;
    logic    mul_hi;
    logic    mul_lo;
    logic    bucket;
    logic    scan_load;
    logic    scan_step;
    logic    fill_rd;
    logic    ent_rd;
    rd_sel_e rd_sel;
    logic    ent_wr;
    logic    wr_new;
    ptr_op_e ptr_op;
    commit_e commit;
    logic    finish;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic fill_full;
    logic fill_zero;
    logic ptr_zero;
    logic ptr_at_fill;
    logic shift_end;
    logic key_gt;
    logic id_match;
    logic total_zero;
    logic cur_nonempty;
    logic scan_last;
  } sts_t;

endpackage

/* hdl/bmpq_ctrl.sv */
`timescale 1ns / 1ps
module bmpq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bmpq_pkg::req_t req_i,
  input  bmpq_pkg::sts_t sts_i,
  output bmpq_pkg::cmd_t cmd_o
);
  import bmpq_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DIFF    = 5'd1;
  localparam logic [4:0] S_MULH    = 5'd2;
  localparam logic [4:0] S_MULL    = 5'd3;
  localparam logic [4:0] S_BKT     = 5'd4;
  localparam logic [4:0] S_FILL    = 5'd5;
  localparam logic [4:0] S_FILLW   = 5'd6;
  localparam logic [4:0] S_INS_RD  = 5'd7;
  localparam logic [4:0] S_INS_CMP = 5'd8;
  localparam logic [4:0] S_REM_RD  = 5'd9;
  localparam logic [4:0] S_REM_CMP = 5'd10;
  localparam logic [4:0] S_SH_RD   = 5'd11;
  localparam logic [4:0] S_SH_WR   = 5'd12;
  localparam logic [4:0] S_CONS    = 5'd13;
  localparam logic [4:0] S_SCAN    = 5'd14;
  localparam logic [4:0] S_CFILL   = 5'd15;
  localparam logic [4:0] S_CRD     = 5'd16;
  localparam logic [4:0] S_CPOP    = 5'd17;

  logic [4:0] state_q, state_d;
  logic       is_ins_q, is_ins_d;
  cmd_t       cmd;

  always_comb begin
    cmd      = '0;
    state_d  = state_q;
    is_ins_d = is_ins_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (req_i.req_type)
            REQ_INSERT: begin
              is_ins_d = 1'b1;
              state_d  = S_DIFF;
            end
            REQ_REMOVE: begin
              is_ins_d = 1'b0;
              state_d  = S_DIFF;
            end
            REQ_CONSUME: state_d = S_CONS;
            default: begin
              cmd.finish = 1'b1;
              cmd.status = ST_OK;
            end
          endcase
        end
      end
      S_DIFF: begin
        cmd.diff = 1'b1;
        state_d  = S_MULH;
      end
      S_MULH: begin
        cmd.mul_hi = 1'b1;
        state_d    = S_MULL;
      end
      S_MULL: begin
        cmd.mul_lo = 1'b1;
        state_d    = S_BKT;
      end
      S_BKT: begin
        cmd.bucket = 1'b1;
        state_d    = S_FILL;
      end
      S_FILL: begin
        cmd.fill_rd = 1'b1;
        state_d     = S_FILLW;
      end
      S_FILLW: begin
        if (is_ins_q) begin
          if (sts_i.fill_full) begin
            cmd.finish = 1'b1;
            cmd.status = ST_FULL;
            state_d    = S_IDLE;
          end else begin
            cmd.ptr_op = PTR_FILL;
            state_d    = S_INS_RD;
          end
        end else if (sts_i.fill_zero) begin
          cmd.finish = 1'b1;
          cmd.status = ST_NOT_FOUND;
          state_d    = S_IDLE;
        end else begin
          cmd.ptr_op = PTR_ZERO;
          state_d    = S_REM_RD;
        end
      end
      S_INS_RD: begin
        if (sts_i.ptr_zero) begin
          cmd.ent_wr = 1'b1;
          cmd.wr_new = 1'b1;
          cmd.commit = CM_INSERT;
          cmd.finish = 1'b1;
          cmd.status = ST_OK;
          state_d    = S_IDLE;
        end else begin
          cmd.ent_rd = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_d    = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        cmd.ent_wr = 1'b1;
        if (sts_i.key_gt) begin
          cmd.ptr_op = PTR_DEC;
          state_d    = S_INS_RD;
        end else begin
          cmd.wr_new = 1'b1;
          cmd.commit = CM_INSERT;
          cmd.finish = 1'b1;
          cmd.status = ST_OK;
          state_d    = S_IDLE;
        end
      end
      S_REM_RD: begin
        if (sts_i.ptr_at_fill) begin
          cmd.finish = 1'b1;
          cmd.status = ST_NOT_FOUND;
          state_d    = S_IDLE;
        end else begin
          cmd.ent_rd = 1'b1;
          cmd.rd_sel = RD_CUR;
          state_d    = S_REM_CMP;
        end
      end
      S_REM_CMP: begin
        if (sts_i.id_match) begin
          state_d = S_SH_RD;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_d    = S_REM_RD;
        end
      end
      S_SH_RD: begin
        if (sts_i.shift_end) begin
          cmd.commit = CM_REMOVE;
          cmd.finish = 1'b1;
          cmd.status = ST_OK;
          state_d    = S_IDLE;
        end else begin
          cmd.ent_rd = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_d    = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.ent_wr = 1'b1;
        cmd.ptr_op = PTR_INC;
        state_d    = S_SH_RD;
      end
      S_CONS: begin
        if (sts_i.total_zero) begin
          cmd.finish = 1'b1;
          cmd.status = ST_EMPTY;
          state_d    = S_IDLE;
        end else begin
          cmd.scan_load = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.cur_nonempty) begin
          cmd.fill_rd = 1'b1;
          state_d     = S_CFILL;
        end else if (sts_i.scan_last) begin
          cmd.finish = 1'b1;
          cmd.status = ST_EMPTY;
          state_d    = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_CFILL: begin
        cmd.ptr_op = PTR_FILL_M1;
        state_d    = S_CRD;
      end
      S_CRD: begin
        cmd.ent_rd = 1'b1;
        cmd.rd_sel = RD_CUR;
        state_d    = S_CPOP;
      end
      S_CPOP: begin
        cmd.commit = CM_POP;
        cmd.finish = 1'b1;
        cmd.status = ST_OK;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      is_ins_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      is_ins_q <= is_ins_d;
    end
  end

  assign busy  = (state_q != S_IDLE);
  assign cmd_o = cmd;

endmodule

/* hdl/bmpq_dp.sv */
`timescale 1ns / 1ps
`include "bucketed_min_priority_queue_macros.svh"
module bmpq_dp #(
  parameter int unsigned NUM_BUCKETS  = bmpq_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned BUCKET_DEPTH = bmpq_pkg::BUCKET_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  input  bmpq_pkg::req_t req_i,
  input  bmpq_pkg::cmd_t cmd_i,
  output bmpq_pkg::sts_t sts_o,
  output logic           done_o,
  output bmpq_pkg::rsp_t rsp_o
);
  import bmpq_pkg::*;

  localparam int unsigned BW     = $clog2(NUM_BUCKETS);
  localparam int unsigned IW     = $clog2(BUCKET_DEPTH);
  localparam int unsigned PW     = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned EDEPTH = NUM_BUCKETS * (2 ** IW);

  logic [31:0]      start_q, inv_q;
  logic [7:0]       last_q;
  logic signed [31:0] key_q;
  logic [15:0]      id_q;
  logic [31:0]      diff_q;
  logic             pos_q;
  logic [47:0]      hi_q, lo_q, product;
  logic [15:0]      mul_b;
  logic [32:0]      d33, lim, qv, bsel;
  logic [48:0]      qsum;
  logic [BW-1:0]    bkt_q, scan_q, scan_d;
  logic [PW-1:0]    ptr_q, rptr, fill, fill_rdata_q, fill_wdata;
  logic             vld_q, fill_we;
  logic [NUM_BUCKETS-1:0] nonempty_q;
  logic [PW-1:0]    fill_mem [NUM_BUCKETS];
  entry_t           ent_mem [EDEPTH];
  entry_t           ent_rd_q, ent_wdata;
  logic [CNT_W-1:0] total_q, total_d;
  rsp_t             rsp_q;
  logic             done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= BUCKET_START_RST;
      inv_q   <= INV_STEP_RST;
      last_q  <= LAST_BUCKET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BUCKET_START: start_q <= cfg_data_i;
        CFG_INV_STEP:     inv_q   <= cfg_data_i;
        CFG_LAST_BUCKET:  last_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign d33     = {key_q[31], key_q} - {start_q[31], start_q};
  assign mul_b   = cmd_i.mul_hi ? inv_q[31:16] : inv_q[15:0];
  assign product = 48'(diff_q) * 48'(mul_b);
  assign qsum    = 49'(hi_q) + 49'(lo_q[47:16]);
  assign qv      = qsum[48:16];
  assign lim     = (33'(last_q) > 33'(NUM_BUCKETS - 1)) ? 33'(NUM_BUCKETS - 1) : 33'(last_q);
  assign bsel    = !pos_q ? '0 : ((qv > lim) ? lim : qv);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q <= req_i.key;
      id_q  <= req_i.tag_id;
    end
    if (cmd_i.diff) begin
      diff_q <= d33[31:0];
      pos_q  <= !d33[32] && (d33 != '0);
    end
    if (cmd_i.mul_hi) hi_q <= product;
    if (cmd_i.mul_lo) lo_q <= product;
  end

  assign fill = vld_q ? fill_rdata_q : '0;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PREV: rptr = ptr_q - PW'(1);
      RD_NEXT: rptr = ptr_q + PW'(1);
      default: rptr = ptr_q;
    endcase
  end

  assign ent_wdata = cmd_i.wr_new ? entry_t'{key: key_q, tag_id: id_q} : ent_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_wr) ent_mem[{bkt_q, ptr_q[IW-1:0]}] <= ent_wdata;
    if (cmd_i.ent_rd) ent_rd_q <= ent_mem[{bkt_q, rptr[IW-1:0]}];
  end

  always_comb begin
    fill_we    = 1'b1;
    fill_wdata = fill;
    total_d    = total_q;
    scan_d     = scan_q;
    case (cmd_i.commit)
      CM_INSERT: begin
        fill_wdata = fill + PW'(1);
        total_d    = total_q + CNT_W'(1);
        if (bkt_q < scan_q) scan_d = bkt_q;
      end
      CM_REMOVE: begin
        fill_wdata = fill - PW'(1);
        total_d    = total_q - CNT_W'(1);
      end
      CM_POP: begin
        fill_wdata = ptr_q;
        total_d    = total_q - CNT_W'(1);
        scan_d     = bkt_q;
      end
      default: fill_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[bkt_q] <= fill_wdata;
    if (cmd_i.fill_rd) fill_rdata_q <= fill_mem[bkt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bkt_q      <= '0;
      scan_q     <= '0;
      total_q    <= '0;
      ptr_q      <= '0;
      vld_q      <= 1'b0;
      nonempty_q <= '0;
      done_q     <= 1'b0;
      rsp_q      <= '0;
    end else begin
      if (cmd_i.bucket) bkt_q <= bsel[BW-1:0];
      else if (cmd_i.scan_load) bkt_q <= scan_q;
      else if (cmd_i.scan_step) bkt_q <= bkt_q + BW'(1);
      if (cmd_i.fill_rd) vld_q <= nonempty_q[bkt_q];
      if (fill_we) nonempty_q[bkt_q] <= (fill_wdata != '0);
      case (cmd_i.ptr_op)
        PTR_FILL:    ptr_q <= fill;
        PTR_ZERO:    ptr_q <= '0;
        PTR_DEC:     ptr_q <= ptr_q - PW'(1);
        PTR_INC:     ptr_q <= ptr_q + PW'(1);
        PTR_FILL_M1: ptr_q <= fill - PW'(1);
        default: ;
      endcase
      scan_q  <= scan_d;
      total_q <= total_d;
      done_q  <= cmd_i.finish;
      if (cmd_i.finish) begin
        rsp_q.out_id      <= (cmd_i.commit == CM_POP) ? ent_rd_q.tag_id : '0;
        rsp_q.status      <= cmd_i.status;
        rsp_q.queue_count <= total_d;
      end
    end
  end

  assign sts_o.fill_full    = (fill == PW'(BUCKET_DEPTH));
  assign sts_o.fill_zero    = (fill == '0);
  assign sts_o.ptr_zero     = (ptr_q == '0);
  assign sts_o.ptr_at_fill  = (ptr_q == fill);
  assign sts_o.shift_end    = ((PW + 1)'(ptr_q) + (PW + 1)'(1)) >= (PW + 1)'(fill);
  assign sts_o.key_gt       = (key_q > ent_rd_q.key);
  assign sts_o.id_match     = (ent_rd_q.tag_id == id_q);
  assign sts_o.total_zero   = (total_q == '0);
  assign sts_o.cur_nonempty = nonempty_q[bkt_q];
  assign sts_o.scan_last    = (bkt_q == BW'(NUM_BUCKETS - 1));

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `BMPQ_ASSERT_IMPL(a_ins_room, clk_i, rst_ni, cmd_i.commit == CM_INSERT, fill != PW'(BUCKET_DEPTH))
  `BMPQ_ASSERT_IMPL(a_pop_held, clk_i, rst_ni, cmd_i.commit == CM_POP, vld_q && (fill != '0))
  `BMPQ_ASSERT_IMPL(a_wr_range, clk_i, rst_ni, cmd_i.ent_wr, ptr_q < PW'(BUCKET_DEPTH))
  `BMPQ_ASSERT_IMPL(a_commit_fin, clk_i, rst_ni, cmd_i.commit != CM_NONE, cmd_i.finish)
  `BMPQ_ASSERT_NEXT(a_pop_scan, clk_i, rst_ni, cmd_i.commit == CM_POP, scan_q == $past(bkt_q))

endmodule

/* hdl/bucketed_min_priority_queue.sv */
`timescale 1ns / 1ps
// Bucketed min-priority queue of (key, id) words.
// Request channel: drive req_i and raise start while busy is low; the word is
// taken at that edge. Types: insert, remove by id, consume smallest key.
// Result channel: done_o is high for exactly one cycle with rsp_o; the
// receiver cannot stall it, so it must sample on that cycle.
// Config channel: cfg_valid_i with cfg_index_i/cfg_data_i; cfg_ready_o is
// always high. Write only while busy is low and no result is pending.
// Insert/remove first find the bucket (subtract, two 32x16 multiplies on one
// shared multiplier, clamp, fill read), then move or compare the entries in
// the bucket one at a time through the entry memory port. Consume skips the
// empty buckets from the scan pointer on, then reads the fill and pops the
// entry. Invalid types and errors finish early. done_o rises in the cycle
// after the last working cycle.
// Throughput: one request at a time; a new one may start on the done cycle.
// Reset: fill counts read as zero at once (per-bucket flags), count and scan
// pointer clear, registers take their defaults; no clearing pass.
module bucketed_min_priority_queue #(
  parameter int unsigned NUM_BUCKETS  = bmpq_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned BUCKET_DEPTH = bmpq_pkg::BUCKET_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bmpq_pkg::req_t req_i,
  output logic           done_o,
  output bmpq_pkg::rsp_t rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i
);
  import bmpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bmpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  bmpq_dp #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  assign cfg_ready_o = 1'b1;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import bmpq_pkg::*;

  localparam int NB = NUM_BUCKETS_DEF;
  localparam int DEPTH = BUCKET_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 5000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  bucketed_min_priority_queue dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // queue shadow state
  logic signed [31:0] slot_key [NB][DEPTH];
  logic [15:0] slot_id [NB][DEPTH];
  int unsigned slot_fill [NB];
  int unsigned scan_ptr;
  int unsigned entries_held;
  logic [31:0] start_reg = BUCKET_START_RST;
  logic [31:0] inv_step_reg = INV_STEP_RST;
  logic [7:0] last_reg = LAST_BUCKET_RST;

  req_t pending_words [$];
  rsp_t expected_rsp [$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int n_full = 0, n_empty = 0, n_missing = 0;
  int gap = 0;
  bit no_gaps = 0;
  longint cycles = 0;

  function automatic int unsigned key_bucket(logic signed [31:0] k);
    longint d;
    longint unsigned ud, a, b, q, lim;
    d = longint'(k) - longint'($signed(start_reg));
    lim = 64'(last_reg);
    if (d <= 0) return 0;
    ud = d;
    a = ud * inv_step_reg[31:16];
    b = ud * inv_step_reg[15:0];
    q = (a + (b >> 16)) >> 16;
    if (q > lim) q = lim;
    return 32'(q);
  endfunction

  function automatic rsp_t apply_request(req_t w);
    rsp_t r;
    int unsigned b, n, p, i;
    r = '0;
    r.status = ST_OK;
    case (w.req_type)
      REQ_INSERT: begin
        b = key_bucket(w.key);
        n = slot_fill[b];
        if (n >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          p = n;
          while (p > 0 && w.key > slot_key[b][p-1]) p--;
          for (i = n; i > p; i--) begin
            slot_key[b][i] = slot_key[b][i-1];
            slot_id[b][i] = slot_id[b][i-1];
          end
          slot_key[b][p] = w.key;
          slot_id[b][p] = w.tag_id;
          slot_fill[b] = n + 1;
          if (b < scan_ptr) scan_ptr = b;
          entries_held++;
        end
      end
      REQ_REMOVE: begin
        b = key_bucket(w.key);
        n = slot_fill[b];
        p = 0;
        while (p < n && slot_id[b][p] != w.tag_id) p++;
        if (p == n) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (i = p; i + 1 < n; i++) begin
            slot_key[b][i] = slot_key[b][i+1];
            slot_id[b][i] = slot_id[b][i+1];
          end
          slot_fill[b] = n - 1;
          entries_held--;
        end
      end
      REQ_CONSUME: begin
        b = scan_ptr;
        if (entries_held != 0)
          while (b < NB && slot_fill[b] == 0) b++;
        if (entries_held == 0 || b >= NB) begin
          r.status = ST_EMPTY;
        end else begin
          n = slot_fill[b];
          scan_ptr = b;
          r.out_id = slot_id[b][n-1];
          slot_fill[b] = n - 1;
          entries_held--;
        end
      end
      default: ;
    endcase
    r.queue_count = entries_held[CNT_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    if (no_gaps || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(15, 50);
    return $urandom_range(1, 4);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_rsp = {expected_rsp, apply_request(req_i)};
        void'(pending_words.pop_front());
        accepted++;
      end
      if (!start || !busy) begin
        if (gap > 0) begin
          gap <= gap - 1;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          start <= 1'b1;
          req_i <= pending_words[0];
          gap <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rsp_o);
        errors++;
      end else begin
        if (rsp_o.out_id !== expected_rsp[0].out_id ||
            rsp_o.status !== expected_rsp[0].status ||
            rsp_o.queue_count !== expected_rsp[0].queue_count) begin
          $display("%0t: mismatch expected id=%h st=%0d cnt=%0d actual id=%h st=%0d cnt=%0d",
                   $time, expected_rsp[0].out_id, expected_rsp[0].status,
                   expected_rsp[0].queue_count, rsp_o.out_id, rsp_o.status,
                   rsp_o.queue_count);
          errors++;
        end
        if (expected_rsp[0].status == ST_FULL) n_full++;
        if (expected_rsp[0].status == ST_EMPTY) n_empty++;
        if (expected_rsp[0].status == ST_NOT_FOUND) n_missing++;
        void'(expected_rsp.pop_front());
        checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_rsp.size());
      $display("** bucketed_min_priority_queue: FAILED **");
      $finish;
    end
  end

  task automatic push_word(logic [1:0] t, logic [31:0] k, logic [15:0] id);
    req_t w;
    w.req_type = t;
    w.key = k;
    w.tag_id = id;
    pending_words = {pending_words, w};
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && expected_rsp.size() == 0 && !start);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_BUCKET_START: start_reg = val;
      CFG_INV_STEP: inv_step_reg = val;
      CFG_LAST_BUCKET: last_reg = val[7:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  logic [31:0] live_key [$];
  logic [15:0] live_id [$];

  task automatic random_phase(int count, int unsigned span);
    int unsigned sel, j;
    logic [31:0] k;
    logic [15:0] id;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        k = ($urandom_range(0, 9) == 0) ? $urandom() : start_reg + $urandom_range(0, span);
        id = 16'($urandom());
        push_word(REQ_INSERT, k, id);
        live_key = {live_key, k};
        live_id = {live_id, id};
      end else if (sel < 65) begin
        if (live_id.size() > 0 && $urandom_range(0, 4) != 0) begin
          j = $urandom_range(0, live_id.size() - 1);
          push_word(REQ_REMOVE, live_key[j], live_id[j]);
          live_key.delete(j);
          live_id.delete(j);
        end else begin
          push_word(REQ_REMOVE, $urandom(), 16'($urandom()));
        end
      end else if (sel < 95) begin
        push_word(REQ_CONSUME, $urandom(), 16'($urandom()));
      end else begin
        push_word(REQ_RSVD, $urandom(), 16'($urandom()));
      end
      if (live_id.size() > 64) begin
        live_key.delete(0);
        live_id.delete(0);
      end
    end
  endtask

  initial begin
    foreach (slot_fill[i]) slot_fill[i] = 0;
    scan_ptr = 0;
    entries_held = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty queue, extreme keys and ids, unknown id, unused type
    push_word(REQ_CONSUME, 32'h0, 16'h0);
    push_word(REQ_REMOVE, 32'h0, 16'hFFFF);
    push_word(REQ_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
    push_word(REQ_INSERT, 32'h8000_0000, 16'h0000);
    push_word(REQ_INSERT, 32'h0000_0000, 16'h1234);
    push_word(REQ_INSERT, 32'h0000_8000, 16'h0001);
    push_word(REQ_INSERT, 32'h0000_8000, 16'h0002);
    push_word(REQ_INSERT, 32'h0000_4000, 16'h0003);
    push_word(REQ_REMOVE, 32'h0000_8000, 16'h5555);
    push_word(REQ_REMOVE, 32'h7FFF_FFFF, 16'hFFFF);
    push_word(REQ_RSVD, 32'hFFFF_FFFF, 16'hFFFF);
    repeat (6) push_word(REQ_CONSUME, 32'hFFFF_FFFF, 16'hFFFF);
    push_word(REQ_INSERT, 32'h0005_0000, 16'hA5A5);
    push_word(REQ_CONSUME, 32'h0, 16'h0);
    drain();

    no_gaps = 1;
    random_phase(200, 32'h0040_0000);
    drain();
    no_gaps = 0;
    random_phase(200, 32'h00FF_FFFF);
    drain();

    write_reg(CFG_LAST_BUCKET, 32'd0);
    random_phase(150, 32'h0010_0000);
    drain();
    write_reg(CFG_BUCKET_START, 32'h8000_0000);
    write_reg(CFG_INV_STEP, 32'hFFFF_FFFF);
    write_reg(CFG_LAST_BUCKET, 32'd3);
    random_phase(150, 32'h0000_0004);
    drain();
    write_reg(CFG_INV_STEP, 32'h0);
    write_reg(CFG_LAST_BUCKET, 32'd255);
    random_phase(120, 32'hFFFF_FFFF);
    drain();
    write_reg(CFG_BUCKET_START, 32'h7FFF_FFFF);
    write_reg(CFG_INV_STEP, 32'h0000_0100);
    random_phase(120, 32'h0);
    drain();
    write_reg(CFG_BUCKET_START, 32'hFFF0_0000);
    write_reg(CFG_INV_STEP, 32'h0008_0000);
    write_reg(CFG_LAST_BUCKET, 32'd40);
    random_phase(230, 32'h0008_0000);
    drain();
    write_reg(CFG_BUCKET_START, BUCKET_START_RST);
    write_reg(CFG_INV_STEP, INV_STEP_RST);
    write_reg(CFG_LAST_BUCKET, 32'(LAST_BUCKET_RST));
    random_phase(200, 32'h0100_0000);
    repeat (40) push_word(REQ_CONSUME, 32'h0, 16'h0);
    wait (pending_words.size() == 0 && expected_rsp.size() == 0);
    repeat (60) @(posedge clk_i);

    $display("Ran %0d requests, checked %0d results over 7 register settings.",
             accepted, checked);
    $display("Seen: %0d full-bucket drops, %0d empty consumes, %0d unknown ids.",
             n_full, n_empty, n_missing);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("** bucketed_min_priority_queue: PASSED **");
    end else begin
      $display("** bucketed_min_priority_queue: FAILED **");
    end
    $finish;
  end
endmodule
